// File: design/ircp_pkg.sv
// shared types, constants and helpers for the row and column projection block
package ircp_pkg;

   localparam int PIXEL_IN_BITS = 16;
   localparam int SUM_BITS      = 28;
   localparam int INDEX_BITS    = 12;
   localparam int CFG_BITS      = 13;
   localparam int CSR_IDX_BITS  = 4;

   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

   // register indexes on the csr channel
   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_FRAME_WIDTH  = 4'd0,
      REG_FRAME_HEIGHT = 4'd1
   } ircp_reg_type;

   // result kind codes
   typedef enum logic {
      KIND_ROW = 1'b0,
      KIND_COL = 1'b1
   } ircp_kind_type;

   // position flags that travel with each pixel
   typedef struct packed {
      logic first_row;
      logic last_row;
      logic row_end;
   } ircp_flags_type;

   // saturating add of a pixel into a sum
   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [PIXEL_IN_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + (SUM_BITS + 1)'(b);
      return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
   endfunction

endpackage

// File: design/ircp_ifs.sv
// channel interfaces for pixels, results and register writes

interface ircp_req_if;
   import ircp_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [PIXEL_IN_BITS-1:0] pixel_value;
   logic                     frame_start;

   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface ircp_rsp_if;
   import ircp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic                  sum_kind;
   logic [INDEX_BITS-1:0] sum_index;
   logic [SUM_BITS-1:0]   sum_value;
   logic                  frame_done;

   modport source (output valid, output sum_kind, output sum_index, output sum_value,
                   output frame_done, input ready);
   modport sink   (input valid, input sum_kind, input sum_index, input sum_value,
                   input frame_done, output ready);
endinterface

interface ircp_csr_if;
   import ircp_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0]     data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/ircp_front.sv
// front end: frame size registers, position counters and running row sum
module ircp_front
   import ircp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   ircp_req_if.sink                        req,
   ircp_csr_if.sink                        csr,
   output logic                            q_valid,
   input  logic                            q_ready,
   output ircp_flags_type                  q_flags,
   output logic [PIXEL_BITS-1:0]           q_pix,
   output logic [$clog2(MAX_WIDTH)-1:0]    q_col,
   output logic [$clog2(MAX_HEIGHT)-1:0]   q_row,
   output logic [SUM_BITS-1:0]             q_row_sum
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int WSZ_W = ($clog2(MAX_WIDTH + 1) > CFG_BITS) ? $clog2(MAX_WIDTH + 1) : CFG_BITS;
   localparam int HSZ_W = ($clog2(MAX_HEIGHT + 1) > CFG_BITS) ? $clog2(MAX_HEIGHT + 1) : CFG_BITS;
   localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

   logic [WSZ_W-1:0] width_ff, width_in, width_wr;
   logic [HSZ_W-1:0] height_ff, height_in, height_wr;
   logic [COL_W-1:0] col_pos_ff, col_pos_in, col_cur;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in, row_cur;
   logic [SUM_BITS-1:0] row_acc_ff, row_acc_in, row_acc_cur, row_sum;
   logic             accept;
   logic             row_end;
   logic             last_row;

   // clamp incoming size writes to the legal range
   always_comb begin
      width_wr = WSZ_W'(csr.data);
      if (width_wr == '0) begin
         width_wr = WSZ_W'(1);
      end else if (width_wr > WSZ_W'(MAX_WIDTH)) begin
         width_wr = WSZ_W'(MAX_WIDTH);
      end
      height_wr = HSZ_W'(csr.data);
      if (height_wr == '0) begin
         height_wr = HSZ_W'(1);
      end else if (height_wr > HSZ_W'(MAX_HEIGHT)) begin
         height_wr = HSZ_W'(MAX_HEIGHT);
      end
   end

   // register write decode
   assign csr.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_FRAME_WIDTH:  width_in  = width_wr;
            REG_FRAME_HEIGHT: height_in = height_wr;
            default: ;
         endcase
      end
   end

   // position classification of the incoming pixel
   always_comb begin
      col_cur     = req.frame_start ? '0 : col_pos_ff;
      row_cur     = req.frame_start ? '0 : row_pos_ff;
      row_acc_cur = req.frame_start ? '0 : row_acc_ff;
      row_end     = (WSZ_W'(col_cur) + WSZ_W'(1)) >= width_ff;
      last_row    = (HSZ_W'(row_cur) + HSZ_W'(1)) >= height_ff;
      row_sum     = sat_add(row_acc_cur, PIXEL_IN_BITS'(req.pixel_value[PIXEL_BITS-1:0]));
   end

   assign req.ready = q_ready;
   assign accept    = req.valid && q_ready;

   // counter update
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      row_acc_in = row_acc_ff;
      if (accept) begin
         if (row_end) begin
            col_pos_in = '0;
            row_acc_in = '0;
            row_pos_in = last_row ? '0 : ROW_W'(row_cur + ROW_W'(1));
         end else begin
            col_pos_in = COL_W'(col_cur + COL_W'(1));
            row_pos_in = row_cur;
            row_acc_in = row_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WSZ_W'(W_RST);
         height_ff  <= HSZ_W'(H_RST);
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         row_acc_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         row_acc_ff <= row_acc_in;
      end
   end

   // queue push
   assign q_valid           = req.valid;
   assign q_flags.first_row = (row_cur == '0);
   assign q_flags.last_row  = last_row;
   assign q_flags.row_end   = row_end;
   assign q_pix             = req.pixel_value[PIXEL_BITS-1:0];
   assign q_col             = col_cur;
   assign q_row             = row_cur;
   assign q_row_sum         = row_sum;

endmodule

// File: design/ircp_fifo.sv
// short transaction queue between front and back
module ircp_fifo
   import ircp_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_ff + PTR_W'(1));
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_ff + PTR_W'(1));
      end
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + CNT_W'(1));
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count above depth");
`endif

endmodule

// File: design/ircp_back.sv
// back end: column accumulator memory, read-modify-write and result output
module ircp_back
   import ircp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_ready,
   input  ircp_flags_type                  q_flags,
   input  logic [PIXEL_BITS-1:0]           q_pix,
   input  logic [$clog2(MAX_WIDTH)-1:0]    q_col,
   input  logic [$clog2(MAX_HEIGHT)-1:0]   q_row,
   input  logic [SUM_BITS-1:0]             q_row_sum,
   ircp_rsp_if.source                      rsp
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   logic [SUM_BITS-1:0] col_mem [MAX_WIDTH];

   // work stage holding the pixel being added into its column
   logic                b2_valid_ff, b2_valid_in;
   ircp_flags_type      b2_flags_ff;
   logic [PIXEL_BITS-1:0] b2_pix_ff;
   logic [COL_W-1:0]    b2_col_ff;
   logic [ROW_W-1:0]    b2_row_ff;
   logic [SUM_BITS-1:0] b2_row_sum_ff;
   logic                col_done_ff, col_done_in;
   logic [SUM_BITS-1:0] rd_ff;
   logic                fwd_hit_ff;
   logic [SUM_BITS-1:0] fwd_val_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   ircp_kind_type         out_kind_ff, out_kind_in;
   logic [INDEX_BITS-1:0] out_index_ff, out_index_in;
   logic [SUM_BITS-1:0]   out_value_ff, out_value_in;
   logic                  out_done_ff, out_done_in;

   logic [SUM_BITS-1:0] mem_val, col_sum;
   logic                out_free, emit, b2_done, load;

   // column sum with bypass of the write that lands on the read edge
   always_comb begin
      mem_val = fwd_hit_ff ? fwd_val_ff : rd_ff;
      col_sum = b2_flags_ff.first_row ? SUM_BITS'(b2_pix_ff)
                                      : sat_add(mem_val, PIXEL_IN_BITS'(b2_pix_ff));
   end

   // result sequencing: column result first, then row result
   always_comb begin
      out_free     = !out_valid_ff || rsp.ready;
      emit         = 1'b0;
      b2_done      = 1'b0;
      col_done_in  = col_done_ff;
      out_kind_in  = out_kind_ff;
      out_index_in = out_index_ff;
      out_value_in = out_value_ff;
      out_done_in  = out_done_ff;
      if (b2_valid_ff) begin
         if (b2_flags_ff.last_row && !col_done_ff) begin
            if (out_free) begin
               emit         = 1'b1;
               out_kind_in  = KIND_COL;
               out_index_in = INDEX_BITS'(b2_col_ff);
               out_value_in = col_sum;
               out_done_in  = 1'b0;
               if (b2_flags_ff.row_end) begin
                  col_done_in = 1'b1;
               end else begin
                  b2_done = 1'b1;
               end
            end
         end else if (b2_flags_ff.row_end) begin
            if (out_free) begin
               emit         = 1'b1;
               out_kind_in  = KIND_ROW;
               out_index_in = INDEX_BITS'(b2_row_ff);
               out_value_in = b2_row_sum_ff;
               out_done_in  = b2_flags_ff.last_row;
               b2_done      = 1'b1;
            end
         end else begin
            b2_done = 1'b1;
         end
      end
      q_ready = !b2_valid_ff || b2_done;
      load    = q_valid && q_ready;
      if (b2_done || load) begin
         col_done_in = 1'b0;
      end
      b2_valid_in = load ? 1'b1 : (b2_done ? 1'b0 : b2_valid_ff);
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b2_valid_ff  <= 1'b0;
         col_done_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         b2_valid_ff  <= b2_valid_in;
         col_done_ff  <= col_done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         b2_flags_ff   <= q_flags;
         b2_pix_ff     <= q_pix;
         b2_col_ff     <= q_col;
         b2_row_ff     <= q_row;
         b2_row_sum_ff <= q_row_sum;
         fwd_hit_ff    <= b2_done && (b2_col_ff == q_col);
         fwd_val_ff    <= col_sum;
      end
      out_kind_ff  <= out_kind_in;
      out_index_ff <= out_index_in;
      out_value_ff <= out_value_in;
      out_done_ff  <= out_done_in;
   end

   // column accumulator memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (b2_done) begin
         col_mem[b2_col_ff] <= col_sum;
      end
      if (load) begin
         rd_ff <= col_mem[q_col];
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.sum_kind   = out_kind_ff;
   assign rsp.sum_index  = out_index_ff;
   assign rsp.sum_value  = out_value_ff;
   assign rsp.frame_done = out_done_ff;

`ifndef ASSERT_OFF
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      b2_valid_ff && !b2_done |=> b2_valid_ff && $stable(b2_col_ff))
      else $error("work stage lost a pending pixel");

   a_col_in_last_row: assert property (@(posedge clock) disable iff (reset)
      emit && out_kind_in == KIND_COL |-> b2_flags_ff.last_row)
      else $error("column result outside the last row");

   a_col_done_dual: assert property (@(posedge clock) disable iff (reset)
      b2_valid_ff && col_done_ff |-> b2_flags_ff.row_end && b2_flags_ff.last_row)
      else $error("column result marked sent on a single result pixel");
`endif

endmodule

// File: design/image_row_column_projection_top.sv
// results reach rsp through the queue, the work stage and the output register
// throughput: one pixel per cycle while rsp is ready; the last pixel of a frame
//   gives two results and stalls the back end, a four-entry queue absorbs this
// the column memory updates by read-modify-write with a write-to-read bypass
// reset: synchronous, clears counters, queue and output; sizes return to 640 x 480
//   or the maximum if smaller, column memory is not cleared since row zero overwrites it
module image_row_column_projection_top
   import ircp_pkg::*;
#(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096,
   parameter int PIXEL_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   ircp_req_if.sink    req_ch,
   ircp_rsp_if.source  rsp_ch,
   ircp_csr_if.sink    csr_ch
);

   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int QUEUE_DEPTH = 4;
   localparam int ENTRY_W     = $bits(ircp_flags_type) + PIXEL_BITS + COL_W + ROW_W + SUM_BITS;

   logic                f_valid, f_ready;
   ircp_flags_type      f_flags;
   logic [PIXEL_BITS-1:0] f_pix;
   logic [COL_W-1:0]    f_col;
   logic [ROW_W-1:0]    f_row;
   logic [SUM_BITS-1:0] f_row_sum;

   logic                b_valid, b_ready;
   ircp_flags_type      b_flags;
   logic [PIXEL_BITS-1:0] b_pix;
   logic [COL_W-1:0]    b_col;
   logic [ROW_W-1:0]    b_row;
   logic [SUM_BITS-1:0] b_row_sum;

   logic [ENTRY_W-1:0]  push_entry, pop_entry;

   ircp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .csr       (csr_ch),
      .q_valid   (f_valid),
      .q_ready   (f_ready),
      .q_flags   (f_flags),
      .q_pix     (f_pix),
      .q_col     (f_col),
      .q_row     (f_row),
      .q_row_sum (f_row_sum)
   );

   // pack and unpack queue entries
   assign push_entry = {f_flags, f_pix, f_col, f_row, f_row_sum};
   assign {b_flags, b_pix, b_col, b_row, b_row_sum} = pop_entry;

   ircp_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (push_entry),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (pop_entry)
   );

   ircp_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (b_valid),
      .q_ready   (b_ready),
      .q_flags   (b_flags),
      .q_pix     (b_pix),
      .q_col     (b_col),
      .q_row     (b_row),
      .q_row_sum (b_row_sum),
      .rsp       (rsp_ch)
   );

endmodule
